### design/qlt_pkg.sv
package qlt_pkg;

   // data path widths
   localparam int SAMPLE_WIDTH = 24;
   localparam int PHASE_WIDTH = 32;
   localparam int SINE_DEPTH = 1024;
   localparam int CHANNELS = 2;

   // sine lookup geometry, quarter wave plus the peak entry
   localparam int IDX_W = $clog2(SINE_DEPTH);
   localparam int QTR = SINE_DEPTH / 4;
   localparam int QTR_W = IDX_W - 2;
   localparam int ROM_AW = QTR_W + 1;

   // q16 magnitudes and gains
   localparam int LFO_W = 17;
   localparam int GAIN_W = 18;
   localparam int DEPTH_W = 17;
   localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(65536);

   // configuration port
   localparam int CSR_DW = 32;
   localparam int CSR_IW = 2;
   localparam logic [CSR_IW-1:0] CSR_LFO_MODE = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_PHASE_STEP = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_MOD_DEPTH = 2'd2;

   typedef logic [LFO_W-1:0] sine_rom_type [QTR+1];

   // |sin| of one quarter-wave point in q16, q30 taylor series
   function automatic logic [LFO_W-1:0] sine_mag(int j);
      longint unsigned r;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      r = longint'(j) * ((64'd1 << 30) / QTR);
      x = (r * 64'd1686629713) >> 30;
      x2 = (x * x) >> 30;
      t = (64'd1 << 30) - x2 / 110;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 72;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
      s = (x * t) >> 30;
      s = (s + (64'd1 << 13)) >> 14;
      if (s > 64'd65536) begin
         s = 64'd65536;
      end
      return LFO_W'(s);
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int j = 0; j <= QTR; j++) begin
         rom[j] = sine_mag(j);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

### design/qlt_if.sv
// input channel: one frame of two stereo signals
interface qlt_req_if;
   import qlt_pkg::*;

   logic valid;
   logic ready;
   logic signed [SAMPLE_WIDTH-1:0] first_left;
   logic signed [SAMPLE_WIDTH-1:0] first_right;
   logic signed [SAMPLE_WIDTH-1:0] second_left;
   logic signed [SAMPLE_WIDTH-1:0] second_right;

   modport source (
      output valid, first_left, first_right, second_left, second_right,
      input ready
   );
   modport sink (
      input valid, first_left, first_right, second_left, second_right,
      output ready
   );
endinterface

// result channel: the modulated frame
interface qlt_rsp_if;
   import qlt_pkg::*;

   logic valid;
   logic ready;
   logic signed [SAMPLE_WIDTH-1:0] first_left_out;
   logic signed [SAMPLE_WIDTH-1:0] first_right_out;
   logic signed [SAMPLE_WIDTH-1:0] second_left_out;
   logic signed [SAMPLE_WIDTH-1:0] second_right_out;

   modport source (
      output valid, first_left_out, first_right_out, second_left_out, second_right_out,
      input ready
   );
   modport sink (
      input valid, first_left_out, first_right_out, second_left_out, second_right_out,
      output ready
   );
endinterface

### design/quadrature_lfo_tremolo.sv
// quadrature tremolo
// req_ch carries one frame: left and right samples of two signals. rsp_ch
// returns the same frame, the first signal scaled by the lfo gain and the
// second by a gain whose lfo runs a quarter turn ahead. both are valid/ready
// channels; a transaction happens when valid and ready are high at a clock edge.
// csr_write_en/csr_index/csr_data write lfo_mode (0), phase_step (1) and
// mod_depth (2); other indexes are ignored. the user must write them only
// while no frame is in flight; the block does not enforce it. per frame, two
// sine lookups feed two gain products; these and four sample products go
// through one shared multiplier, one product per cycle. the result then sits
// in an output register, so the next frame is accepted while it waits, once
// the sequencer is back in idle. if the receiver still holds the previous
// result when a frame finishes, the block waits in its last step until that
// result is taken. the lfo phase advances by phase_step as each result is
// written. synchronous reset clears the phase, the registers to their
// defaults (mode 0, step 0, full depth) and the output valid; the sine table
// is a constant quarter-wave rom and needs no fill.
module quadrature_lfo_tremolo (
   input  logic                         clock,
   input  logic                         reset,
   qlt_req_if.sink                      req_ch,
   qlt_rsp_if.source                    rsp_ch,
   input  logic                         csr_write_en,
   input  logic [qlt_pkg::CSR_IW-1:0]   csr_index,
   input  logic [qlt_pkg::CSR_DW-1:0]   csr_data
);
   import qlt_pkg::*;

   localparam int MUL_A_W = SAMPLE_WIDTH + 2;
   localparam int PROD_W = MUL_A_W + GAIN_W;
   localparam int Y_W = PROD_W - 15;
   localparam logic signed [Y_W-1:0] SAT_HI = Y_W'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
   localparam logic signed [Y_W-1:0] SAT_LO = ~SAT_HI;

   // sequencer codes
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_ROM1  = 4'd1;
   localparam logic [3:0] ST_GAIN1 = 4'd2;
   localparam logic [3:0] ST_GAIN2 = 4'd3;
   localparam logic [3:0] ST_MUL0  = 4'd4;
   localparam logic [3:0] ST_MUL1  = 4'd5;
   localparam logic [3:0] ST_MUL2  = 4'd6;
   localparam logic [3:0] ST_MUL3  = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;

   // gain = round(lfo*d) + 1 - d in q16
   function automatic logic [GAIN_W-1:0] mix_gain(logic [2*LFO_W-1:0] pl,
                                                 logic [DEPTH_W-1:0] d);
      logic [2*LFO_W-1:0] rnd;
      logic [GAIN_W:0] g;
      rnd = pl + (2*LFO_W)'(32768);
      g = (GAIN_W+1)'(rnd[2*LFO_W-1:16]) + (GAIN_W+1)'(DEPTH_ONE) - (GAIN_W+1)'(d);
      return g[GAIN_W-1:0];
   endfunction

   // round half up, drop q16, saturate to the sample range
   function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
      logic signed [PROD_W-1:0] p);
      logic signed [PROD_W:0] sum;
      logic signed [Y_W-1:0] y;
      sum = {p[PROD_W-1], p} + (PROD_W+1)'(32768);
      y = sum[PROD_W:16];
      if (y > SAT_HI) begin
         y = SAT_HI;
      end else if (y < SAT_LO) begin
         y = SAT_LO;
      end
      return y[SAMPLE_WIDTH-1:0];
   endfunction

   // configuration and phase
   logic                     mode_ff, mode_in;
   logic [PHASE_WIDTH-1:0]   step_ff, step_in;
   logic [DEPTH_W-1:0]       depth_ff, depth_in;
   logic [PHASE_WIDTH-1:0]   phase_ff, phase_in;
   // sequencer and data path
   logic [3:0]               state_ff, state_in;
   logic signed [SAMPLE_WIDTH-1:0] x0_ff, x0_in, x1_ff, x1_in, x2_ff, x2_in, x3_ff, x3_in;
   logic [LFO_W-1:0]         rom_q_ff, rom_q_in;
   logic                     neg_ff, neg_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [GAIN_W-1:0]        gain1_ff, gain1_in, gain2_ff, gain2_in;
   logic signed [SAMPLE_WIDTH-1:0] y0_ff, y0_in, y1_ff, y1_in, y2_ff, y2_in;
   // output register
   logic                     out_valid_ff, out_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] o0_ff, o0_in, o1_ff, o1_in, o2_ff, o2_in, o3_ff, o3_in;

   logic                     accept;
   logic                     out_free;
   logic [DEPTH_W-1:0]       depth_sat;
   logic [IDX_W-1:0]         tab_idx;
   logic [ROM_AW-1:0]        rom_addr;
   logic [LFO_W:0]           half_sum;
   logic [LFO_W-1:0]         lfo_val;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [GAIN_W-1:0] mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic                     mul_en;

   assign accept = req_ch.valid && req_ch.ready;
   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign depth_sat = (depth_ff > DEPTH_ONE) ? DEPTH_ONE : depth_ff;

   // sine lookup address, the quadrature lfo sits a quarter table ahead
   always_comb begin
      tab_idx = phase_ff[PHASE_WIDTH-1 -: IDX_W]
              + ((state_ff == ST_GAIN1) ? IDX_W'(QTR) : IDX_W'(0));
      if (tab_idx[QTR_W]) begin
         rom_addr = ROM_AW'(QTR) - {1'b0, tab_idx[QTR_W-1:0]};
      end else begin
         rom_addr = {1'b0, tab_idx[QTR_W-1:0]};
      end
   end

   // lfo value from the registered table entry
   always_comb begin
      if (neg_ff) begin
         half_sum = (LFO_W+1)'(65537) - {1'b0, rom_q_ff};
      end else begin
         half_sum = (LFO_W+1)'(65537) + {1'b0, rom_q_ff};
      end
      lfo_val = mode_ff ? half_sum[LFO_W:1] : rom_q_ff;
   end

   // shared multiplier operand select
   always_comb begin
      mul_en = 1'b1;
      case (state_ff)
         ST_GAIN1, ST_GAIN2: begin
            mul_a = MUL_A_W'(lfo_val);
            mul_b = GAIN_W'(depth_sat);
         end
         ST_MUL0: begin
            mul_a = MUL_A_W'(x0_ff);
            mul_b = gain1_ff;
         end
         ST_MUL1: begin
            mul_a = MUL_A_W'(x1_ff);
            mul_b = gain1_ff;
         end
         ST_MUL2: begin
            mul_a = MUL_A_W'(x2_ff);
            mul_b = gain2_ff;
         end
         ST_MUL3: begin
            mul_a = MUL_A_W'(x3_ff);
            mul_b = gain2_ff;
         end
         default: begin
            mul_en = 1'b0;
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // sequencer and next values
   always_comb begin
      mode_in = mode_ff;
      step_in = step_ff;
      depth_in = depth_ff;
      phase_in = phase_ff;
      state_in = state_ff;
      x0_in = x0_ff;
      x1_in = x1_ff;
      x2_in = x2_ff;
      x3_in = x3_ff;
      rom_q_in = rom_q_ff;
      neg_in = neg_ff;
      prod_in = mul_en ? mul_p : prod_ff;
      gain1_in = gain1_ff;
      gain2_in = gain2_ff;
      y0_in = y0_ff;
      y1_in = y1_ff;
      y2_in = y2_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      o0_in = o0_ff;
      o1_in = o1_ff;
      o2_in = o2_ff;
      o3_in = o3_ff;

      // register writes
      if (csr_write_en) begin
         case (csr_index)
            CSR_LFO_MODE:   mode_in = csr_data[0];
            CSR_PHASE_STEP: step_in = csr_data[PHASE_WIDTH-1:0];
            CSR_MOD_DEPTH:  depth_in = csr_data[DEPTH_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x0_in = req_ch.first_left;
               x1_in = req_ch.first_right;
               x2_in = req_ch.second_left;
               x3_in = req_ch.second_right;
               state_in = ST_ROM1;
            end
         end
         ST_ROM1: begin
            rom_q_in = SINE_ROM[rom_addr];
            neg_in = tab_idx[IDX_W-1];
            state_in = ST_GAIN1;
         end
         ST_GAIN1: begin
            rom_q_in = SINE_ROM[rom_addr];
            neg_in = tab_idx[IDX_W-1];
            state_in = ST_GAIN2;
         end
         ST_GAIN2: begin
            gain1_in = mix_gain(prod_ff[2*LFO_W-1:0], depth_sat);
            state_in = ST_MUL0;
         end
         ST_MUL0: begin
            gain2_in = mix_gain(prod_ff[2*LFO_W-1:0], depth_sat);
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            y0_in = round_sat(prod_ff);
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            y1_in = round_sat(prod_ff);
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            y2_in = round_sat(prod_ff);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // wait here while the previous result is still held
            if (out_free) begin
               o0_in = y0_ff;
               o1_in = (CHANNELS >= 2) ? y1_ff : '0;
               o2_in = y2_ff;
               o3_in = (CHANNELS >= 2) ? round_sat(prod_ff) : '0;
               out_valid_in = 1'b1;
               phase_in = phase_ff + step_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         step_ff <= '0;
         depth_ff <= DEPTH_ONE;
         phase_ff <= '0;
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         step_ff <= step_in;
         depth_ff <= depth_in;
         phase_ff <= phase_in;
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      x0_ff <= x0_in;
      x1_ff <= x1_in;
      x2_ff <= x2_in;
      x3_ff <= x3_in;
      rom_q_ff <= rom_q_in;
      neg_ff <= neg_in;
      prod_ff <= prod_in;
      gain1_ff <= gain1_in;
      gain2_ff <= gain2_in;
      y0_ff <= y0_in;
      y1_ff <= y1_in;
      y2_ff <= y2_in;
      o0_ff <= o0_in;
      o1_ff <= o1_in;
      o2_ff <= o2_in;
      o3_ff <= o3_in;
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.first_left_out = o0_ff;
   assign rsp_ch.first_right_out = o1_ff;
   assign rsp_ch.second_left_out = o2_ff;
   assign rsp_ch.second_right_out = o3_ff;

endmodule

### design/qlt_checker.sv
module qlt_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [qlt_pkg::SAMPLE_WIDTH-1:0] first_left_out,
   input logic signed [qlt_pkg::SAMPLE_WIDTH-1:0] first_right_out,
   input logic signed [qlt_pkg::SAMPLE_WIDTH-1:0] second_left_out,
   input logic signed [qlt_pkg::SAMPLE_WIDTH-1:0] second_right_out
);
   import qlt_pkg::*;

   // reset leaves no result pending
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a frame keeps the input closed through its working states
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready ##1 !req_ready ##1 !req_ready
         ##1 !req_ready ##1 !req_ready ##1 !req_ready ##1 !req_ready)
      else $error("input reopened while a frame was in work");

   // a new result appears only at the end of a frame's work
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without a frame in work");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(first_left_out)
         && $stable(first_right_out) && $stable(second_left_out)
         && $stable(second_right_out))
      else $error("stalled result changed");

endmodule

bind quadrature_lfo_tremolo qlt_checker u_qlt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .first_left_out   (rsp_ch.first_left_out),
   .first_right_out  (rsp_ch.first_right_out),
   .second_left_out  (rsp_ch.second_left_out),
   .second_right_out (rsp_ch.second_right_out)
);
